@@ sv/string_to_unsigned_parser_unit_macros.svh @@
// Assertion macros shared by the parser unit RTL.
`ifndef STRING_TO_UNSIGNED_PARSER_UNIT_MACROS_SVH
`define STRING_TO_UNSIGNED_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define STOU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define STOU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/stou_pkg.sv @@
// Shared types, constants and the character classifier of the parser unit.
`timescale 1ns / 1ps
package stou_pkg;

   localparam int CH_W               = 8;
   localparam int RADIX_W            = 6;
   localparam int VALUE_W            = 64;
   localparam int CONSUMED_W         = 16;
   localparam int DIGIT_W            = 6;
   localparam int POSITION_WIDTH_DEF = 16;
   localparam int CMD_DEPTH          = 4;
   localparam int RSP_DEPTH          = 2;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;

   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

   // One classified character, as queued between front and back.
   typedef struct packed {
      logic               first;
      logic               space;
      logic               plus;
      logic               minus;
      logic               zero;
      logic               lower_x;
      logic               is_digit;
      logic [DIGIT_W-1:0] dval;
   } cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0]    value;
      logic [CONSUMED_W-1:0] consumed;
   } rsp_type;

   function automatic cmd_type classify(input logic [CH_W-1:0] ch, input logic first);
      cmd_type c;
      c          = '0;
      c.first    = first;
      c.space    = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
      c.plus     = (ch == CH_PLUS);
      c.minus    = (ch == CH_MINUS);
      c.zero     = (ch == CH_ZERO);
      c.lower_x  = (ch == CH_LO_X);
      if (ch inside {[CH_ZERO:CH_NINE]}) begin
         c.is_digit = 1'b1;
         c.dval     = DIGIT_W'(ch - CH_ZERO);
      end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
         c.is_digit = 1'b1;
         c.dval     = DIGIT_W'(ch - CH_UP_A + LETTER_OFS);
      end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
         c.is_digit = 1'b1;
         c.dval     = DIGIT_W'(ch - CH_LO_A + LETTER_OFS);
      end
      return c;
   endfunction

endpackage

@@ sv/stou_fifo.sv @@
// Small synchronous queue with registered count and pointers.
`timescale 1ns / 1ps
module stou_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  logic [WIDTH-1:0] wdata_i,
   output logic             full_o,
   input  logic             pop_i,
   output logic             empty_o,
   output logic [WIDTH-1:0] rdata_o
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full_o  = (count_ff == CW'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign rdata_o = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata_i;
      end
   end

endmodule

@@ sv/stou_front.sv @@
// Front end: radix register, input beat acceptance and character classification.
`timescale 1ns / 1ps
module stou_front
   import stou_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push_i,
   input  logic [CH_W-1:0]    ch_i,
   input  logic               first_i,
   output logic               full_o,
   input  logic               csr_valid_i,
   output logic               csr_ready_o,
   input  logic [RADIX_W-1:0] csr_radix_i,
   output logic [RADIX_W-1:0] radix_o,
   output logic               cmd_push_o,
   output cmd_type            cmd_o,
   input  logic               cmd_full_i
);
   logic [RADIX_W-1:0] radix_ff;

   assign csr_ready_o = 1'b1;
   assign radix_o     = radix_ff;
   assign full_o      = cmd_full_i;
   assign cmd_push_o  = push_i && !cmd_full_i;
   assign cmd_o       = classify(ch_i, first_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid_i && csr_ready_o) begin
         radix_ff <= csr_radix_i;
      end
   end

endmodule

@@ sv/stou_back.sv @@
// Back end: parse state machine, accumulator and result formation.
`timescale 1ns / 1ps
`include "string_to_unsigned_parser_unit_macros.svh"
module stou_back
   import stou_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [RADIX_W-1:0] radix_i,
   input  logic               cmd_empty_i,
   input  cmd_type            cmd_i,
   output logic               cmd_pop_o,
   input  logic               rsp_full_i,
   output logic               rsp_push_o,
   output rsp_type            rsp_o
);
   localparam int WW = (POSITION_WIDTH > CONSUMED_W) ? POSITION_WIDTH : CONSUMED_W;

   typedef enum logic [4:0] {
      PH_DONE   = 5'b00001,
      PH_LEAD   = 5'b00010,
      PH_SIGNED = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   phase_type                 phase_ff, phase_in, p;
   logic [RADIX_W-1:0]        base_ff, base_in, base, digit_base;
   logic                      neg_ff, neg_in, neg;
   logic [VALUE_W-1:0]        acc_ff, acc_in, acc;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in, pos, pos_inc;
   logic [VALUE_W-1:0]        prod;
   logic [WW-1:0]             pos_wide;
   logic                      take, live, to_signed, run_digit, emit;

   // product wraps modulo 2^64
   assign prod = acc * VALUE_W'(digit_base);

   always_comb begin
      take       = !cmd_empty_i && !rsp_full_i;
      live       = cmd_i.first || (phase_ff != PH_DONE);
      p          = cmd_i.first ? PH_LEAD : phase_ff;
      base       = cmd_i.first ? radix_i : base_ff;
      neg        = cmd_i.first ? 1'b0 : neg_ff;
      acc        = cmd_i.first ? '0 : acc_ff;
      pos        = cmd_i.first ? '0 : pos_ff;
      pos_inc    = (pos == '1) ? pos : pos + 1'b1;
      digit_base = base;
      to_signed  = 1'b0;
      run_digit  = 1'b0;
      emit       = 1'b0;
      phase_in   = phase_ff;
      base_in    = base_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      if (take && live) begin
         phase_in = p;
         base_in  = base;
         neg_in   = neg;
         acc_in   = acc;
         pos_in   = pos;
         case (p)
            PH_LEAD: begin
               if (cmd_i.space) begin
                  pos_in = pos_inc;
               end else if (cmd_i.plus || cmd_i.minus) begin
                  neg_in   = cmd_i.minus;
                  pos_in   = pos_inc;
                  phase_in = PH_SIGNED;
               end else begin
                  to_signed = 1'b1;
               end
            end
            PH_SIGNED: to_signed = 1'b1;
            PH_ZERO: begin
               if (cmd_i.lower_x && (base == BASE_AUTO || base == BASE_HEX)) begin
                  base_in  = BASE_HEX;
                  pos_in   = pos_inc;
                  phase_in = PH_DIGITS;
               end else begin
                  digit_base = (base == BASE_AUTO) ? BASE_OCT : base;
                  run_digit  = 1'b1;
               end
            end
            PH_DIGITS: run_digit = 1'b1;
            default: ;
         endcase
         if (to_signed) begin
            if (cmd_i.zero) begin
               pos_in   = pos_inc;
               phase_in = PH_ZERO;
            end else begin
               digit_base = (base == BASE_AUTO) ? BASE_DEC : base;
               run_digit  = 1'b1;
            end
         end
         if (run_digit) begin
            base_in = digit_base;
            if (cmd_i.is_digit && (cmd_i.dval < digit_base)) begin
               acc_in   = prod + VALUE_W'(cmd_i.dval);
               pos_in   = pos_inc;
               phase_in = PH_DIGITS;
            end else begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end
         end
      end
   end

   // result uses the state before the stop character
   always_comb begin
      pos_wide       = WW'(pos);
      rsp_o.value    = neg ? (VALUE_W'(0) - acc) : acc;
      rsp_o.consumed = (pos_wide > WW'({CONSUMED_W{1'b1}})) ? '1 : pos_wide[CONSUMED_W-1:0];
   end

   assign cmd_pop_o  = take;
   assign rsp_push_o = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      pos_ff  <= pos_in;
   end

   `STOU_ASSERT_NOW(a_push_needs_pop, rsp_push_o, cmd_pop_o, "result without consumed beat")
   `STOU_ASSERT_NOW(a_digits_base, phase_ff == PH_DIGITS, base_ff != '0, "digit phase with base 0")
   `STOU_ASSERT_NOW(a_zero_counted, phase_ff == PH_ZERO, pos_ff != '0, "leading zero not counted")
   `STOU_ASSERT_NEXT(a_first_opens, cmd_pop_o && cmd_i.first, (phase_ff != PH_DONE) || $past(rsp_push_o), "first beat lost")

endmodule

@@ sv/string_to_unsigned_parser_unit.sv @@
// Top level of the streaming string to unsigned integer parser.
//
//   channel   ports                                  direction
//   request   push, full, req_ch, req_first          in
//   response  empty, pop, rsp_value, rsp_consumed    out
//   csr       valid, ready, csr_radix                in
//
// One character per cycle while neither queue is full; the parse loop (one 64x6
// multiply-add per character) sets that figure. With both queues empty, a result
// passes the command and response queue registers. A four-entry command queue
// separates classification from parsing, a two-entry queue holds results; either
// side may stall without losing beats. Synchronous reset; radix resets to 10.
`timescale 1ns / 1ps
module string_to_unsigned_parser_unit
   import stou_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [CH_W-1:0]       req_ch,
   input  logic                  req_first,
   output logic                  empty,
   input  logic                  pop,
   output logic [VALUE_W-1:0]    rsp_value,
   output logic [CONSUMED_W-1:0] rsp_consumed,
   input  logic                  valid,
   output logic                  ready,
   input  logic [RADIX_W-1:0]    csr_radix
);
   logic [RADIX_W-1:0] radix;
   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type            cmd_wr, cmd_rd;
   logic               res_push, res_full;
   rsp_type            res_wr, res_rd;

   stou_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .ch_i        (req_ch),
      .first_i     (req_first),
      .full_o      (full),
      .csr_valid_i (valid),
      .csr_ready_o (ready),
      .csr_radix_i (csr_radix),
      .radix_o     (radix),
      .cmd_push_o  (cmd_push),
      .cmd_o       (cmd_wr),
      .cmd_full_i  (cmd_full)
   );

   stou_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push_i  (cmd_push),
      .wdata_i (cmd_wr),
      .full_o  (cmd_full),
      .pop_i   (cmd_pop),
      .empty_o (cmd_empty),
      .rdata_o (cmd_rd)
   );

   stou_back #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .radix_i     (radix),
      .cmd_empty_i (cmd_empty),
      .cmd_i       (cmd_rd),
      .cmd_pop_o   (cmd_pop),
      .rsp_full_i  (res_full),
      .rsp_push_o  (res_push),
      .rsp_o       (res_wr)
   );

   stou_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push_i  (res_push),
      .wdata_i (res_wr),
      .full_o  (res_full),
      .pop_i   (pop),
      .empty_o (empty),
      .rdata_o (res_rd)
   );

   assign rsp_value    = res_rd.value;
   assign rsp_consumed = res_rd.consumed;

endmodule
